// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: rtl/htsr_pkg.sv
// Shared constants, codes and types of the handle table.
`timescale 1ns / 1ps

package htsr_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int WORD_W          = 32;
  localparam int OP_W            = 3;
  localparam int STATUS_W        = 2;
  localparam int S_DATA_W        = 5 * WORD_W;
  localparam int M_DATA_W        = 3 * WORD_W;

  localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_POS   = 3'd2;
  localparam logic [OP_W-1:0] OP_READ_POS  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_SCALE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_SCALE = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
  } pair_t;

  typedef struct packed {
    logic we_handle;
    logic we_pos;
    logic we_scale;
  } store_we_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   new_handle;
    logic [WORD_W-1:0]   data_x;
    logic [WORD_W-1:0]   data_y;
  } result_t;

endpackage

// File: rtl/htsr_store.sv
// Record columns: handle, position and scale memories with one write and one read port.
`timescale 1ns / 1ps

module htsr_store
  import htsr_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  localparam int AW = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  store_we_t         we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] whandle,
  input  pair_t             wpos,
  input  pair_t             wscale,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rhandle,
  output pair_t             rpos,
  output pair_t             rscale
);

  logic [WORD_W-1:0] handle_mem [ENTRIES];
  pair_t             pos_mem    [ENTRIES];
  pair_t             scale_mem  [ENTRIES];

  always_ff @(posedge clk) begin
    if (we.we_handle) begin
      handle_mem[waddr] <= whandle;
    end
    if (we.we_pos) begin
      pos_mem[waddr] <= wpos;
    end
    if (we.we_scale) begin
      scale_mem[waddr] <= wscale;
    end
    rhandle <= handle_mem[raddr];
    rpos    <= pos_mem[raddr];
    rscale  <= scale_mem[raddr];
  end

endmodule

// File: rtl/htsr_seq.sv
// Sequencer: handle lookup with one shared comparator, add, swap-remove, set and read.
`timescale 1ns / 1ps

module htsr_seq
  import htsr_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT,
  localparam int AW = $clog2(ENTRIES),
  localparam int CW = $clog2(ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [WORD_W-1:0] in_handle,
  input  pair_t             in_pos,
  input  pair_t             in_scale,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res,
  output store_we_t         we,
  output logic [AW-1:0]     waddr,
  output logic [WORD_W-1:0] whandle,
  output pair_t             wpos,
  output pair_t             wscale,
  output logic [AW-1:0]     raddr,
  input  logic [WORD_W-1:0] rhandle,
  input  pair_t             rpos,
  input  pair_t             rscale
);

  typedef enum logic [2:0] {
    S_IDLE, S_START, S_PROBE, S_SCAN, S_FOUND, S_READ, S_MOVE, S_DONE
  } state_t;

  state_t            state;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] key;
  pair_t             pos;
  pair_t             scale;
  logic [CW-1:0]     count;
  logic [WORD_W-1:0] next_handle;
  logic [CW-1:0]     scan_idx;
  logic [AW-1:0]     probe_addr;
  logic [AW-1:0]     slot;

  logic [WORD_W-1:0] count_ext;
  logic              key_in_range;
  logic              hit;
  logic              full;
  logic [AW-1:0]     last_addr;

  assign count_ext    = {{(WORD_W-CW){1'b0}}, count};
  assign key_in_range = key < count_ext;
  assign hit          = rhandle == key;
  assign full         = count == CW'(ENTRIES);
  assign last_addr    = AW'(count - 1'b1);

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    we      = '0;
    waddr   = slot;
    whandle = next_handle;
    wpos    = pos;
    wscale  = scale;
    raddr   = slot;
    unique case (state)
      S_START: begin
        if (op == OP_ADD) begin
          waddr = count[AW-1:0];
          if (!full) begin
            we = '{we_handle: 1'b1, we_pos: 1'b1, we_scale: 1'b1};
          end
        end else begin
          raddr = key_in_range ? key[AW-1:0] : '0;
        end
      end
      S_PROBE: raddr = '0;
      S_SCAN:  raddr = scan_idx[AW-1:0];
      S_FOUND: begin
        raddr = (op == OP_REMOVE) ? last_addr : slot;
        we.we_pos   = op == OP_SET_POS;
        we.we_scale = op == OP_SET_SCALE;
      end
      S_MOVE: begin
        we      = '{we_handle: 1'b1, we_pos: 1'b1, we_scale: 1'b1};
        whandle = rhandle;
        wpos    = rpos;
        wscale  = rscale;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    probe_addr <= raddr;
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      next_handle <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_op;
            key   <= in_handle;
            pos   <= in_pos;
            scale <= in_scale;
            res   <= '0;
            state <= S_START;
          end
        end
        S_START: begin
          case (op) inside
            OP_ADD: begin
              if (full) begin
                res.status <= STATUS_FULL;
              end else begin
                res.new_handle <= next_handle;
                next_handle    <= next_handle + 32'd1;
                count          <= count + 1'b1;
              end
              state <= S_DONE;
            end
            OP_REMOVE, OP_SET_POS, OP_READ_POS, OP_SET_SCALE, OP_READ_SCALE: begin
              if (count == '0) begin
                res.status <= STATUS_NOT_FOUND;
                state      <= S_DONE;
              end else if (key_in_range) begin
                state <= S_PROBE;
              end else begin
                scan_idx <= CW'(1);
                state    <= S_SCAN;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_PROBE: begin
          if (hit) begin
            slot  <= probe_addr;
            state <= S_FOUND;
          end else begin
            scan_idx <= CW'(1);
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            slot  <= probe_addr;
            state <= S_FOUND;
          end else if (scan_idx == count) begin
            res.status <= STATUS_NOT_FOUND;
            state      <= S_DONE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_FOUND: begin
          case (op) inside
            OP_REMOVE: begin
              if (slot != last_addr) begin
                state <= S_MOVE;
              end else begin
                count <= count - 1'b1;
                state <= S_DONE;
              end
            end
            OP_READ_POS, OP_READ_SCALE: state <= S_READ;
            default: state <= S_DONE;
          endcase
        end
        S_READ: begin
          {res.data_x, res.data_y} <= (op == OP_READ_POS) ? rpos : rscale;
          state                    <= S_DONE;
        end
        S_MOVE: begin
          count <= count - 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/handle_table_swap_remove_unit.sv
// Top level of the dense handle table with swap-remove.
`timescale 1ns / 1ps

// Dense table of up to ENTRIES records (handle, position pair, scale pair),
// driven by one command beat on the slave stream and answered by exactly one
// result beat on the master stream. Add appends a record and returns a handle
// from a wrapping 32-bit counter (status full when the table is full); remove
// moves the last record into the freed slot; set and read find the record by
// handle, first trying the slot whose index equals the handle, then scanning
// from slot 0 for the lowest match. The block takes one command at a time:
// add and unknown ops go from the start state straight to the result; a
// lookup whose handle sits in its own slot is checked in a probe state, and
// otherwise the slots are scanned in turn. The scan is paced by the handle
// memory's single read port feeding the one shared 32-bit comparator, one
// slot per cycle. A registered output stage holds a finished result so the
// next command can be accepted while the result waits.
// Memories come up undefined; only records in slots below the live count are used.
module handle_table_swap_remove_unit
  import htsr_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // handle, pos_x, pos_y, scale_x, scale_y (lowest bits first)
  input  logic [S_DATA_W-1:0] s_tdata,
  // op
  input  logic [OP_W-1:0]     s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // new_handle, data_x, data_y (lowest bits first)
  output logic [M_DATA_W-1:0] m_tdata,
  // status
  output logic [STATUS_W-1:0] m_tuser
);

  localparam int AW = $clog2(ENTRIES);

  pair_t             in_pos;
  pair_t             in_scale;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_res;
  store_we_t         we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] whandle;
  pair_t             wpos;
  pair_t             wscale;
  logic [AW-1:0]     raddr;
  logic [WORD_W-1:0] rhandle;
  pair_t             rpos;
  pair_t             rscale;

  // Unpack the command beat.
  assign in_pos   = '{x: s_tdata[63:32],  y: s_tdata[95:64]};
  assign in_scale = '{x: s_tdata[127:96], y: s_tdata[159:128]};

  htsr_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_handle (s_tdata[31:0]),
    .in_pos    (in_pos),
    .in_scale  (in_scale),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .we        (we),
    .waddr     (waddr),
    .whandle   (whandle),
    .wpos      (wpos),
    .wscale    (wscale),
    .raddr     (raddr),
    .rhandle   (rhandle),
    .rpos      (rpos),
    .rscale    (rscale)
  );

  htsr_store #(.ENTRIES(ENTRIES)) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .whandle (whandle),
    .wpos    (wpos),
    .wscale  (wscale),
    .raddr   (raddr),
    .rhandle (rhandle),
    .rpos    (rpos),
    .rscale  (rscale)
  );

  // Output stage: load when empty or draining this cycle, drop when taken.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.data_y, out_res.data_x, out_res.new_handle};
  assign m_tuser = out_res.status;

endmodule

// File: rtl/htsr_checker.sv
// Port-level checker for the handle table, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module htsr_checker
  import htsr_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [STATUS_W-1:0] m_tuser
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `ASSERT_IMPLY(a_status_code, clk, rst, m_tvalid, m_tuser == STATUS_OK || m_tuser == STATUS_NOT_FOUND || m_tuser == STATUS_FULL)
  `ASSERT_IMPLY(a_fail_zero, clk, rst, m_tvalid && (m_tuser == STATUS_NOT_FOUND || m_tuser == STATUS_FULL), m_tdata == '0)

endmodule

bind handle_table_swap_remove_unit htsr_checker u_htsr_checker (.*);

// File: bench/htsr_result_checker.sv
// Checker for the handle table: watches both streams, predicts each result and compares.
`timescale 1ns / 1ps

module htsr_result_checker
  import htsr_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [OP_W-1:0]     s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic [STATUS_W-1:0] m_tuser,
  output int                  mismatches,
  output int                  pending,
  output int                  results_seen,
  output int                  full_seen,
  output int                  missing_seen
);

  // shadow of the table columns and counters
  logic [WORD_W-1:0] id_col[ENTRIES];
  logic [WORD_W-1:0] px_col[ENTRIES];
  logic [WORD_W-1:0] py_col[ENTRIES];
  logic [WORD_W-1:0] sx_col[ENTRIES];
  logic [WORD_W-1:0] sy_col[ENTRIES];
  int unsigned       live_count;
  logic [WORD_W-1:0] id_next;

  result_t expected_q[$];
  int      err_count;
  int      n_results;
  int      n_full;
  int      n_missing;

  // own slot first, else lowest matching slot
  function automatic bit locate(input logic [WORD_W-1:0] h, output int slot);
    slot = 0;
    if (h < live_count && id_col[h] == h) begin
      slot = int'(h);
      return 1'b1;
    end
    for (int i = 0; i < int'(live_count); i++) begin
      if (id_col[i] == h) begin
        slot = i;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic result_t apply_command(input logic [OP_W-1:0] op,
                                            input logic [WORD_W-1:0] h,
                                            input logic [WORD_W-1:0] px,
                                            input logic [WORD_W-1:0] py,
                                            input logic [WORD_W-1:0] sx,
                                            input logic [WORD_W-1:0] sy);
    result_t r;
    int      slot;
    int      last;
    r = '0;
    case (op)
      OP_ADD: begin
        if (live_count >= ENTRIES) begin
          r.status = STATUS_FULL;
        end else begin
          id_col[live_count] = id_next;
          px_col[live_count] = px;
          py_col[live_count] = py;
          sx_col[live_count] = sx;
          sy_col[live_count] = sy;
          r.new_handle = id_next;
          id_next = id_next + 1'b1;
          live_count++;
        end
      end
      OP_REMOVE, OP_SET_POS, OP_READ_POS, OP_SET_SCALE, OP_READ_SCALE: begin
        if (!locate(h, slot)) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          case (op)
            OP_REMOVE: begin
              // swap the last record into the freed slot
              last = int'(live_count) - 1;
              id_col[slot] = id_col[last];
              px_col[slot] = px_col[last];
              py_col[slot] = py_col[last];
              sx_col[slot] = sx_col[last];
              sy_col[slot] = sy_col[last];
              live_count--;
            end
            OP_SET_POS: begin
              px_col[slot] = px;
              py_col[slot] = py;
            end
            OP_READ_POS: begin
              r.data_x = px_col[slot];
              r.data_y = py_col[slot];
            end
            OP_SET_SCALE: begin
              sx_col[slot] = sx;
              sy_col[slot] = sy;
            end
            default: begin
              r.data_x = sx_col[slot];
              r.data_y = sy_col[slot];
            end
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (err_count < 40) begin
      $display("[%0t] result %0d: %s", $time, n_results, what);
    end
    err_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      live_count = 0;
      id_next = '0;
      expected_q.delete();
      err_count = 0;
      n_results = 0;
      n_full = 0;
      n_missing = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.status     = m_tuser;
        got.new_handle = m_tdata[WORD_W-1:0];
        got.data_x     = m_tdata[2*WORD_W-1:WORD_W];
        got.data_y     = m_tdata[3*WORD_W-1:2*WORD_W];
        n_results++;
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with no command outstanding");
        end else begin
          want = expected_q.pop_front();
          if (got.status != want.status)
            report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
          if (got.new_handle != want.new_handle)
            report_mismatch($sformatf("new_handle got %h want %h",
                                      got.new_handle, want.new_handle));
          if (got.data_x != want.data_x)
            report_mismatch($sformatf("data_x got %h want %h", got.data_x, want.data_x));
          if (got.data_y != want.data_y)
            report_mismatch($sformatf("data_y got %h want %h", got.data_y, want.data_y));
          if (want.status == STATUS_FULL) n_full++;
          if (want.status == STATUS_NOT_FOUND) n_missing++;
        end
      end
      if (s_tvalid && s_tready) begin
        expected_q.push_back(apply_command(s_tuser,
                                           s_tdata[WORD_W-1:0],
                                           s_tdata[2*WORD_W-1:WORD_W],
                                           s_tdata[3*WORD_W-1:2*WORD_W],
                                           s_tdata[4*WORD_W-1:3*WORD_W],
                                           s_tdata[5*WORD_W-1:4*WORD_W]));
      end
    end
    mismatches   <= err_count;
    pending      <= expected_q.size();
    results_seen <= n_results;
    full_seen    <= n_full;
    missing_seen <= n_missing;
  end

endmodule

// File: bench/tb_top.sv
// Stimulus and verdict for the handle table swap-remove unit.
`timescale 1ns / 1ps

module tb_top;
  import htsr_pkg::*;

  localparam int ENTRIES        = ENTRIES_DEFAULT;
  localparam int RANDOM_ITEMS   = 1950;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_LEN   = 400;
  localparam int HOLD_OFF_AFTER = 400;

  // op codes the block does not define; they must answer ok with zero data
  localparam logic [OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_7 = 3'd7;

  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  logic                clk;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic [OP_W-1:0]     s_tuser  = '0;
  logic                m_tready = 1'b0;
  wire                 s_tready;
  wire                 m_tvalid;
  wire [M_DATA_W-1:0]  m_tdata;
  wire [STATUS_W-1:0]  m_tuser;

  int mismatches;
  int pending;
  int results_seen;
  int full_seen;
  int missing_seen;

  // stimulus-side view of which handles are live, used only to aim lookups
  logic [WORD_W-1:0] live_ids[$];
  logic [WORD_W-1:0] issued = '0;
  int                sent_beats = 0;
  int                burst_left = 1;

  // receiver pattern state
  rx_mode_t rx_mode   = RX_OPEN;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     held_off  = 1'b0;
  int       quiet_cycles = 0;

  handle_table_swap_remove_unit #(.ENTRIES(ENTRIES)) DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  htsr_result_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .full_seen    (full_seen),
    .missing_seen (missing_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one command beat and hold it until accepted. Then track live handles
  // and, at the end of a burst, sometimes drop valid for a random gap.
  task automatic push_command(input logic [OP_W-1:0]   op,
                              input logic [WORD_W-1:0] h,
                              input logic [WORD_W-1:0] px,
                              input logic [WORD_W-1:0] py,
                              input logic [WORD_W-1:0] sx,
                              input logic [WORD_W-1:0] sy);
    int pause;
    int idx;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {sy, sx, py, px, h};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_beats++;

    if (op == OP_ADD && live_ids.size() < ENTRIES) begin
      live_ids.push_back(issued);
      issued = issued + 1'b1;
    end else if (op == OP_REMOVE) begin
      idx = -1;
      foreach (live_ids[i]) if (idx < 0 && live_ids[i] == h) idx = i;
      if (idx >= 0) live_ids.delete(idx);
    end

    burst_left--;
    if (burst_left <= 0) begin
      // mostly short bursts, now and then a long unbroken run
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 150)
                                               : $urandom_range(1, 24);
      pause = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (pause != 0) begin
        s_tvalid <= 1'b0;
        repeat (pause) @(posedge clk);
      end
    end
  endtask

  // Skew data words toward the extremes now and then.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // Mostly hit a live handle; else a stale small handle or a random word.
  function automatic logic [WORD_W-1:0] pick_handle();
    if (live_ids.size() != 0 && $urandom_range(0, 99) < 85)
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
    if ($urandom_range(0, 1) != 0)
      return $urandom();
    return $urandom_range(0, int'(issued) + 2);
  endfunction

  // Receiver: random stall patterns, plus one long hold-off so the block
  // fills up and backs pressure onto the command stream.
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      rx_mode   <= RX_OPEN;
      mode_left <= 50;
      hold_left <= 0;
      held_off  <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_off && sent_beats >= HOLD_OFF_AFTER) begin
      held_off  <= 1'b1;
      hold_left <= HOLD_OFF_LEN;
      m_tready  <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= ($urandom_range(0, 1) != 0);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= ~m_tready;
      endcase
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, pending);
        $display("handle_table_swap_remove_unit regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int               target_fill;
    int               phase_left;
    int               roll;
    int               add_w;
    int               rem_w;
    logic [OP_W-1:0]  op;

    target_fill = 0;
    phase_left  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: misses on an empty table
    push_command(OP_READ_POS,  '0,       '0, '0, '0, '0);
    push_command(OP_REMOVE,    ALL_ONES, '0, '0, '0, '0);
    push_command(OP_SET_SCALE, '0,       ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    // three records with extreme and checkerboard words
    push_command(OP_ADD, ALL_ONES, '0, '0, '0, '0);
    push_command(OP_ADD, '0, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    push_command(OP_ADD, '0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    push_command(OP_READ_POS,   32'd0, '0, '0, '0, '0);
    push_command(OP_READ_SCALE, 32'd1, '0, '0, '0, '0);
    push_command(OP_SET_POS,    32'd2, ALL_ONES, '0, 32'h1234_5678, 32'h9ABC_DEF0);
    push_command(OP_READ_POS,   32'd2, '0, '0, '0, '0);
    push_command(OP_SET_SCALE,  32'd0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, ALL_ONES, ALL_ONES);
    push_command(OP_READ_SCALE, 32'd0, '0, '0, '0, '0);
    // undefined op codes with every field set
    push_command(OP_UNUSED_6, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    push_command(OP_UNUSED_7, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    // swap-remove: handle 2 moves into slot 0, so its lookup must scan
    push_command(OP_REMOVE,     32'd0, '0, '0, '0, '0);
    push_command(OP_READ_POS,   32'd2, '0, '0, '0, '0);
    push_command(OP_READ_SCALE, 32'd1, '0, '0, '0, '0);
    push_command(OP_REMOVE,     32'd0, '0, '0, '0, '0);
    push_command(OP_REMOVE,     32'd2, '0, '0, '0, '0);
    push_command(OP_READ_POS,   32'd1, '0, '0, '0, '0);
    push_command(OP_REMOVE,     32'd1, '0, '0, '0, '0);
    push_command(OP_READ_SCALE, 32'd1, '0, '0, '0, '0);
    push_command(OP_ADD, '0, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'hFFFF_FFFE);

    // Random: the fill level drifts toward a target that changes per phase,
    // so the table runs empty, half full and full (with refused adds) in turn.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 4))
          0:       target_fill = 0;
          1:       target_fill = 4;
          2:       target_fill = 24;
          3:       target_fill = 48;
          default: target_fill = ENTRIES + 8;
        endcase
        phase_left = $urandom_range(150, 300);
      end
      phase_left--;

      if (live_ids.size() < target_fill) begin
        add_w = 55;
        rem_w = 8;
      end else begin
        add_w = 8;
        rem_w = 45;
      end

      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
      end else if (roll < 3 + add_w) begin
        op = OP_ADD;
      end else if (roll < 3 + add_w + rem_w) begin
        op = OP_REMOVE;
      end else begin
        case ($urandom_range(0, 3))
          0:       op = OP_SET_POS;
          1:       op = OP_READ_POS;
          2:       op = OP_SET_SCALE;
          default: op = OP_READ_SCALE;
        endcase
      end
      push_command(op, pick_handle(), rand_word(), rand_word(), rand_word(), rand_word());
    end

    s_tvalid <= 1'b0;
    // let the checker see the last accept before trusting its count
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (ENTRIES + 16) @(posedge clk);

    $display("Covered %0d commands and %0d results, table full on %0d adds,",
             sent_beats, results_seen, full_seen);
    $display("handle missing on %0d lookups, one long output stall with input backpressure.",
             missing_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("handle_table_swap_remove_unit regression: pass");
    end else begin
      $display("handle_table_swap_remove_unit regression: fail");
    end
    $finish;
  end

endmodule
